/* design/lpr_pkg.sv */
// Shared types and constants for the longest-prefix route lookup.
// Used by lpr_cell, lpr_chain and longest_prefix_route_lookup.
package lpr_pkg;

    localparam int MAX_ROUTES = 64;
    localparam int PORT_COUNT = 16;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int TTL_W      = 8;
    localparam int PORT_W     = 4;
    localparam int COUNT_W    = $clog2(MAX_ROUTES + 1);
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [2:0] {
        ST_FORWARDED   = 3'd0,
        ST_TTL_EXPIRED = 3'd1,
        ST_NO_ROUTE    = 3'd2,
        ST_ADDED       = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              hop_present;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_t;

    // Search token walking the chain: destination plus best match so far.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dest;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic              hop_present;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } token_t;

endpackage

/* design/longest_prefix_route_lookup.sv */
// IPv4 longest-prefix-match forwarding table, top level.
// Slave stream takes add and forward requests; master stream returns one
// status result per request. Depends on lpr_pkg and lpr_chain.
//
// Usage:
//   s_axis_tuser selects the request: 0 adds a route, 1 forwards a datagram.
//   Every request produces exactly one result on the m_axis side.
//   One request is in work at a time. Add, table-full and TTL-expired
//   results appear in the cycle after acceptance. A forward lookup walks a
//   token through the row of MAX_ROUTES route cells, one cell per cycle,
//   and its result is registered once the token leaves the tail.
//   s_axis_tready is high when no lookup is in flight and the output
//   register is empty or being drained in the same cycle.
//   Reset empties the table (route count zero) and drops any pending result;
//   route cells need no clearing since only stored entries are compared.
//   If the receiver stalls, the result holds in the output register and
//   no new request is taken until it is drained.
module longest_prefix_route_lookup
    import lpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // dest_addr, hop_limit, prefix_value, prefix_bits, hop_present,
    // hop_addr, port_in, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // port_out, forward_addr, new_hop_limit, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]            m_axis_tuser
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TTL_W-1:0]   ttl_reg, ttl_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [PORT_W-1:0]  out_port_reg, out_port_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [TTL_W-1:0]   out_ttl_reg, out_ttl_next;

    logic               accept;
    logic               opcode;
    logic [ADDR_W-1:0]  dest_addr;
    logic [TTL_W-1:0]   hop_limit;
    logic [ADDR_W-1:0]  prefix_value;
    logic [LEN_W-1:0]   prefix_bits;
    logic               hop_present;
    logic [ADDR_W-1:0]  hop_addr;
    logic [PORT_W-1:0]  port_in;
    logic               table_full;
    logic               shift_en;
    route_t             route_new;
    token_t             tok_in;
    token_t             tok_out;

    assign opcode       = s_axis_tuser;
    assign dest_addr    = s_axis_tdata[31:0];
    assign hop_limit    = s_axis_tdata[39:32];
    assign prefix_value = s_axis_tdata[71:40];
    assign prefix_bits  = s_axis_tdata[77:72];
    assign hop_present  = s_axis_tdata[78];
    assign hop_addr     = s_axis_tdata[110:79];
    assign port_in      = s_axis_tdata[114:111];

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign table_full    = count_reg == COUNT_W'(MAX_ROUTES);
    assign shift_en      = accept && !opcode && !table_full;

    always_comb
    begin
        route_new.prefix      = prefix_value;
        route_new.len         = (prefix_bits > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : prefix_bits;
        route_new.hop_present = hop_present;
        route_new.hop         = hop_addr;
        route_new.port        = PORT_W'(port_in % PORT_COUNT);
    end

    always_comb
    begin
        tok_in       = '0;
        tok_in.valid = accept && opcode && (hop_limit > TTL_W'(1));
        tok_in.dest  = dest_addr;
    end

    lpr_chain u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .route_new (route_new),
        .count     (count_reg),
        .tok_in    (tok_in),
        .tok_out   (tok_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ttl_next        = ttl_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_port_next   = out_port_reg;
        out_addr_next   = out_addr_reg;
        out_ttl_next    = out_ttl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_port_next = '0;
                    out_addr_next = '0;
                    out_ttl_next  = '0;
                    if (!opcode)
                    begin
                        out_valid_next = 1'b1;
                        if (table_full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            out_status_next = ST_ADDED;
                            count_next      = count_reg + COUNT_W'(1);
                        end
                    end
                    else if (hop_limit <= TTL_W'(1))
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_TTL_EXPIRED;
                    end
                    else
                    begin
                        ttl_next   = hop_limit - TTL_W'(1);
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (tok_out.valid)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (tok_out.found)
                    begin
                        out_status_next = ST_FORWARDED;
                        out_port_next   = tok_out.port;
                        out_addr_next   = tok_out.hop_present ? tok_out.hop : tok_out.dest;
                        out_ttl_next    = ttl_reg;
                    end
                    else
                    begin
                        out_status_next = ST_NO_ROUTE;
                        out_port_next   = '0;
                        out_addr_next   = '0;
                        out_ttl_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ttl_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_FORWARDED;
            out_port_reg   <= '0;
            out_addr_reg   <= '0;
            out_ttl_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ttl_reg        <= ttl_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_port_reg   <= out_port_next;
            out_addr_reg   <= out_addr_next;
            out_ttl_reg    <= out_ttl_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - PORT_W - ADDR_W - TTL_W){1'b0}},
                            out_ttl_reg, out_addr_reg, out_port_reg};

endmodule

/* design/lpr_cell.sv */
// One route cell: holds a single route, shifts it on an add, and updates
// the passing search token with this route if it matches longer.
// Depends on lpr_pkg.
module lpr_cell
    import lpr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  logic   active,
    input  route_t route_in,
    output route_t route_out,
    input  token_t tok_in,
    output token_t tok_out
);

    route_t            route_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic [ADDR_W-1:0] mask;
    logic              hit;
    logic              take;

    assign mask = ~({ADDR_W{1'b1}} >> route_reg.len);
    assign hit  = ((route_reg.prefix ^ tok_in.dest) & mask) == '0;
    // Newer routes sit nearer the head, so equal length keeps the earlier pick.
    assign take = active && hit && (!tok_in.found || (route_reg.len > tok_in.len));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found       = 1'b1;
            tok_next.len         = route_reg.len;
            tok_next.hop_present = route_reg.hop_present;
            tok_next.hop         = route_reg.hop;
            tok_next.port        = route_reg.port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            route_reg <= route_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign route_out = route_reg;
    assign tok_out   = tok_reg;

endmodule

/* design/lpr_chain.sv */
// Row of MAX_ROUTES route cells. Routes shift in at the head, newest first;
// the search token enters at the head and leaves at the tail.
// Depends on lpr_pkg and lpr_cell.
module lpr_chain
    import lpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  route_t             route_new,
    input  logic [COUNT_W-1:0] count,
    input  token_t             tok_in,
    output token_t             tok_out
);

    route_t route_link [MAX_ROUTES+1];
    token_t tok_link   [MAX_ROUTES+1];

    assign route_link[0] = route_new;
    assign tok_link[0]   = tok_in;

    for (genvar i = 0; i < MAX_ROUTES; i++)
    begin : g_cell
        logic active;

        assign active = COUNT_W'(i) < count;

        lpr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .active    (active),
            .route_in  (route_link[i]),
            .route_out (route_link[i+1]),
            .tok_in    (tok_link[i]),
            .tok_out   (tok_link[i+1])
        );
    end

    assign tok_out = tok_link[MAX_ROUTES];

endmodule
